@@ rtl/core/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared constants, types and the header name table.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  localparam int HEAD_LIMIT      = 4096;
  localparam int LINE_LIMIT      = 1024;
  localparam int METHOD_LIMIT    = 16;
  localparam int PATH_LIMIT      = 1024;
  localparam int VERSION_LIMIT   = 16;
  localparam int SEQUENCE_DIGITS = 16;

  localparam int HEAD_CW = $clog2(HEAD_LIMIT + 1);
  localparam int LINE_CW = $clog2(LINE_LIMIT + 1);
  localparam int VAL_W   = 31;
  localparam int NUM_HDR = 5;

  localparam logic [VAL_W-1:0] SAT31 = {VAL_W{1'b1}};

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_GAP1    = 3'd1,
    PH_PATH    = 3'd2,
    PH_GAP2    = 3'd3,
    PH_VERSION = 3'd4,
    PH_NAME    = 3'd5,
    PH_VALUE   = 3'd6,
    PH_SKIP    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIELD  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // field tags
  localparam logic [2:0] TAG_METHOD  = 3'd0;
  localparam logic [2:0] TAG_PATH    = 3'd1;
  localparam logic [2:0] TAG_VERSION = 3'd2;
  localparam logic [2:0] TAG_HOST    = 3'd3;
  localparam logic [2:0] TAG_AGENT   = 3'd4;
  localparam logic [2:0] TAG_CTYPE   = 3'd5;

  // header ids (0 is none)
  localparam logic [2:0] HDR_NONE  = 3'd0;
  localparam logic [2:0] HDR_HOST  = 3'd1;
  localparam logic [2:0] HDR_AGENT = 3'd2;
  localparam logic [2:0] HDR_CLEN  = 3'd3;
  localparam logic [2:0] HDR_CTYPE = 3'd4;
  localparam logic [2:0] HDR_SEQ   = 3'd5;

  // error causes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_HEAD  = 3'd1;
  localparam logic [2:0] ERR_LINE  = 3'd2;
  localparam logic [2:0] ERR_RLINE = 3'd3;
  localparam logic [2:0] ERR_VALUE = 3'd4;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        tag;
    logic [7:0]        fbyte;
    logic [VAL_W-1:0]  clen;
    logic [VAL_W-1:0]  seq;
    logic [2:0]        cause;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // length of each header name, lower case
  function automatic logic [3:0] name_len(input logic [2:0] idx);
    logic [3:0] len;
    case (idx)
      3'd0:    len = 4'd4;
      3'd1:    len = 4'd10;
      3'd2:    len = 4'd14;
      3'd3:    len = 4'd12;
      default: len = 4'd15;
    endcase
    return len;
  endfunction

  // lower-case character of a header name at a position
  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [15:0][7:0] txt;
    case (idx)
      3'd0:    txt = {"host", 96'h0};
      3'd1:    txt = {"user-agent", 48'h0};
      3'd2:    txt = {"content-length", 16'h0};
      3'd3:    txt = {"content-type", 32'h0};
      default: txt = {"sequence-number", 8'h0};
    endcase
    return txt[4'd15 - pos];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hrhp_front.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser front end
// Takes one word per cycle while take is high, tracks parse state and forms result records.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [7:0]          data_byte,
  output hrhp_pkg::result_t        res,
  output logic                     res_valid
);

  hrhp_pkg::phase_t                 phase_r, phase_nxt;
  logic [hrhp_pkg::HEAD_CW-1:0]     head_r, head_nxt;
  logic [hrhp_pkg::LINE_CW-1:0]     line_r, line_nxt;
  logic [hrhp_pkg::LINE_CW-1:0]     tok_r, tok_nxt;
  logic [hrhp_pkg::NUM_HDR-1:0]     mask_r, mask_nxt;
  logic [2:0]                       active_r, active_nxt;
  logic [hrhp_pkg::VAL_W-1:0]       len_r, len_nxt;
  logic [hrhp_pkg::VAL_W-1:0]       seq_r, seq_nxt;
  logic [1:0]                       term_r, term_nxt;
  logic [1:0]                       vstage_r, vstage_nxt;
  logic                             ddone_r, ddone_nxt;

  // clocked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hrhp_pkg::PH_METHOD;
      head_r   <= '0;
      line_r   <= '0;
      tok_r    <= '0;
      mask_r   <= '1;
      active_r <= hrhp_pkg::HDR_NONE;
      len_r    <= '0;
      seq_r    <= '0;
      term_r   <= '0;
      vstage_r <= '0;
      ddone_r  <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      head_r   <= head_nxt;
      line_r   <= line_nxt;
      tok_r    <= tok_nxt;
      mask_r   <= mask_nxt;
      active_r <= active_nxt;
      len_r    <= len_nxt;
      seq_r    <= seq_nxt;
      term_r   <= term_nxt;
      vstage_r <= vstage_nxt;
      ddone_r  <= ddone_nxt;
    end
  end

  // decimal accumulate with saturation
  function automatic logic [hrhp_pkg::VAL_W-1:0] acc_digit(
      input logic [hrhp_pkg::VAL_W-1:0] acc, input logic [7:0] b);
    logic [hrhp_pkg::VAL_W+3:0] wide;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{hrhp_pkg::VAL_W{1'b0}}, b[3:0]};
    return (wide > {4'b0, hrhp_pkg::SAT31}) ? hrhp_pkg::SAT31
                                            : wide[hrhp_pkg::VAL_W-1:0];
  endfunction

  logic                         is_cr, is_lf, blank, digit, line_end, done;
  logic [7:0]                   lc;
  logic [hrhp_pkg::LINE_CW-1:0] tok_eff, tok_inc, tok_sat;
  logic [hrhp_pkg::NUM_HDR-1:0] alive;
  logic [hrhp_pkg::VAL_W-1:0]   len_upd, seq_upd;

  // next state and result
  always_comb begin
    is_cr  = (data_byte == hrhp_pkg::CH_CR);
    is_lf  = (data_byte == hrhp_pkg::CH_LF);
    blank  = (data_byte == hrhp_pkg::CH_SP) || (data_byte == hrhp_pkg::CH_TAB);
    digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    lc     = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ? data_byte + 8'd32 : data_byte;
    line_end = 1'b0;
    done     = 1'b0;

    phase_nxt  = phase_r;
    head_nxt   = head_r;
    line_nxt   = line_r;
    tok_nxt    = tok_r;
    mask_nxt   = mask_r;
    active_nxt = active_r;
    len_nxt    = len_r;
    seq_nxt    = seq_r;
    vstage_nxt = vstage_r;
    ddone_nxt  = ddone_r;
    term_nxt   = '0;

    res       = '0;
    res_valid = 1'b0;

    tok_eff = '0;
    tok_inc = '0;
    tok_sat = '0;
    alive   = '0;
    len_upd = len_r;
    seq_upd = seq_r;

    // track the terminator
    if (is_cr) begin
      term_nxt = (term_r == 2'd2) ? 2'd3 : 2'd1;
      line_end = 1'b1;
    end else if (is_lf) begin
      if (term_r == 2'd3) begin
        done = 1'b1;
      end else if (term_r == 2'd1) begin
        term_nxt = 2'd2;
      end else begin
        line_end = 1'b1;
      end
    end
    if (head_r < hrhp_pkg::HEAD_CW'(hrhp_pkg::HEAD_LIMIT)) begin
      head_nxt = head_r + 1'b1;
    end

    if (done) begin
      // end of head: report unless the head was rejected, and restart
      if (phase_r != hrhp_pkg::PH_SKIP) begin
        res_valid = 1'b1;
        res.kind  = hrhp_pkg::KIND_DONE;
        res.clen  = len_r;
        res.seq   = seq_r;
      end
      phase_nxt  = hrhp_pkg::PH_METHOD;
      head_nxt   = '0;
      line_nxt   = '0;
      tok_nxt    = '0;
      mask_nxt   = '1;
      active_nxt = hrhp_pkg::HDR_NONE;
      len_nxt    = '0;
      seq_nxt    = '0;
      term_nxt   = '0;
      vstage_nxt = '0;
      ddone_nxt  = 1'b0;
    end else if (phase_r == hrhp_pkg::PH_SKIP) begin
      // drop words until the terminator
    end else if (head_nxt >= hrhp_pkg::HEAD_CW'(hrhp_pkg::HEAD_LIMIT - 1)) begin
      res_valid = 1'b1;
      res.kind  = hrhp_pkg::KIND_REJECT;
      res.cause = hrhp_pkg::ERR_HEAD;
      phase_nxt = hrhp_pkg::PH_SKIP;
    end else if (line_end) begin
      // close the line, or reject it if it ends too early
      if (phase_r == hrhp_pkg::PH_METHOD || phase_r == hrhp_pkg::PH_GAP1 ||
          phase_r == hrhp_pkg::PH_PATH || phase_r == hrhp_pkg::PH_GAP2) begin
        res_valid = 1'b1;
        res.kind  = hrhp_pkg::KIND_REJECT;
        res.cause = hrhp_pkg::ERR_RLINE;
        phase_nxt = hrhp_pkg::PH_SKIP;
      end else if (phase_r == hrhp_pkg::PH_VALUE && vstage_r == 2'd0) begin
        res_valid = 1'b1;
        res.kind  = hrhp_pkg::KIND_REJECT;
        res.cause = hrhp_pkg::ERR_VALUE;
        phase_nxt = hrhp_pkg::PH_SKIP;
      end else begin
        phase_nxt  = hrhp_pkg::PH_NAME;
        line_nxt   = '0;
        tok_nxt    = '0;
        mask_nxt   = '1;
        active_nxt = hrhp_pkg::HDR_NONE;
        vstage_nxt = '0;
        ddone_nxt  = 1'b0;
      end
    end else if (!is_lf) begin
      line_nxt = line_r + 1'b1;
      if (line_nxt >= hrhp_pkg::LINE_CW'(hrhp_pkg::LINE_LIMIT)) begin
        res_valid = 1'b1;
        res.kind  = hrhp_pkg::KIND_REJECT;
        res.cause = hrhp_pkg::ERR_LINE;
        phase_nxt = hrhp_pkg::PH_SKIP;
      end else begin
        unique case (phase_r)
          hrhp_pkg::PH_METHOD: begin
            if (blank) begin
              if (tok_r == '0) begin
                res_valid = 1'b1;
                res.kind  = hrhp_pkg::KIND_REJECT;
                res.cause = hrhp_pkg::ERR_RLINE;
                phase_nxt = hrhp_pkg::PH_SKIP;
              end else begin
                phase_nxt = hrhp_pkg::PH_GAP1;
              end
            end else if (tok_r >= hrhp_pkg::LINE_CW'(hrhp_pkg::METHOD_LIMIT - 1)) begin
              res_valid = 1'b1;
              res.kind  = hrhp_pkg::KIND_REJECT;
              res.cause = hrhp_pkg::ERR_RLINE;
              phase_nxt = hrhp_pkg::PH_SKIP;
            end else begin
              tok_nxt   = tok_r + 1'b1;
              res_valid = 1'b1;
              res.kind  = hrhp_pkg::KIND_FIELD;
              res.tag   = hrhp_pkg::TAG_METHOD;
              res.fbyte = data_byte;
            end
          end
          hrhp_pkg::PH_GAP1, hrhp_pkg::PH_PATH: begin
            tok_eff = (phase_r == hrhp_pkg::PH_GAP1) ? '0 : tok_r;
            if (blank) begin
              if (phase_r == hrhp_pkg::PH_PATH) begin
                phase_nxt = hrhp_pkg::PH_GAP2;
              end
            end else if (tok_eff >= hrhp_pkg::LINE_CW'(hrhp_pkg::PATH_LIMIT - 1)) begin
              res_valid = 1'b1;
              res.kind  = hrhp_pkg::KIND_REJECT;
              res.cause = hrhp_pkg::ERR_RLINE;
              phase_nxt = hrhp_pkg::PH_SKIP;
            end else begin
              phase_nxt = hrhp_pkg::PH_PATH;
              tok_nxt   = tok_eff + 1'b1;
              res_valid = 1'b1;
              res.kind  = hrhp_pkg::KIND_FIELD;
              res.tag   = hrhp_pkg::TAG_PATH;
              res.fbyte = data_byte;
            end
          end
          hrhp_pkg::PH_GAP2, hrhp_pkg::PH_VERSION: begin
            tok_eff = (phase_r == hrhp_pkg::PH_GAP2) ? '0 : tok_r;
            if (blank && phase_r == hrhp_pkg::PH_GAP2) begin
              // hold in the gap
            end else if (tok_eff >= hrhp_pkg::LINE_CW'(hrhp_pkg::VERSION_LIMIT - 1)) begin
              res_valid = 1'b1;
              res.kind  = hrhp_pkg::KIND_REJECT;
              res.cause = hrhp_pkg::ERR_RLINE;
              phase_nxt = hrhp_pkg::PH_SKIP;
            end else begin
              phase_nxt = hrhp_pkg::PH_VERSION;
              tok_nxt   = tok_eff + 1'b1;
              res_valid = 1'b1;
              res.kind  = hrhp_pkg::KIND_FIELD;
              res.tag   = hrhp_pkg::TAG_VERSION;
              res.fbyte = data_byte;
            end
          end
          hrhp_pkg::PH_NAME: begin
            // match the name prefix against all headers at once
            if (mask_r != '0) begin
              for (int i = 0; i < hrhp_pkg::NUM_HDR; i++) begin
                alive[i] = mask_r[i] &&
                           (tok_r < hrhp_pkg::LINE_CW'(hrhp_pkg::name_len(3'(i)))) &&
                           (hrhp_pkg::name_char(3'(i), tok_r[3:0]) == lc);
              end
              mask_nxt = alive;
              tok_inc  = tok_r + 1'b1;
              tok_nxt  = tok_inc;
              for (int i = 0; i < hrhp_pkg::NUM_HDR; i++) begin
                if (alive[i] &&
                    tok_inc == hrhp_pkg::LINE_CW'(hrhp_pkg::name_len(3'(i)))) begin
                  active_nxt = 3'(i + 1);
                  phase_nxt  = hrhp_pkg::PH_VALUE;
                  vstage_nxt = 2'd0;
                end
              end
            end
          end
          hrhp_pkg::PH_VALUE: begin
            if (vstage_r == 2'd0) begin
              if (data_byte == hrhp_pkg::CH_COLON) begin
                vstage_nxt = 2'd1;
                tok_nxt    = '0;
                ddone_nxt  = 1'b0;
                if (active_r == hrhp_pkg::HDR_CLEN) len_nxt = '0;
                if (active_r == hrhp_pkg::HDR_SEQ) seq_nxt = '0;
              end
            end else if (!(vstage_r == 2'd1 && blank)) begin
              vstage_nxt = 2'd2;
              tok_sat = (tok_r < hrhp_pkg::LINE_CW'(hrhp_pkg::LINE_LIMIT)) ? tok_r + 1'b1
                                                                         : tok_r;
              tok_nxt = tok_sat;
              if (!ddone_r) begin
                if (!digit) begin
                  ddone_nxt = 1'b1;
                end else begin
                  len_upd = acc_digit(len_r, data_byte);
                  seq_upd = acc_digit(seq_r, data_byte);
                end
              end
              if (active_r == hrhp_pkg::HDR_CLEN) begin
                len_nxt = len_upd;
              end else if (active_r == hrhp_pkg::HDR_SEQ) begin
                if (tok_sat >= hrhp_pkg::LINE_CW'(hrhp_pkg::SEQUENCE_DIGITS)) begin
                  res_valid = 1'b1;
                  res.kind  = hrhp_pkg::KIND_REJECT;
                  res.cause = hrhp_pkg::ERR_VALUE;
                  phase_nxt = hrhp_pkg::PH_SKIP;
                  ddone_nxt = ddone_r;
                end else begin
                  seq_nxt = seq_upd;
                end
              end else begin
                res_valid = 1'b1;
                res.kind  = hrhp_pkg::KIND_FIELD;
                res.fbyte = data_byte;
                case (active_r)
                  hrhp_pkg::HDR_HOST:  res.tag = hrhp_pkg::TAG_HOST;
                  hrhp_pkg::HDR_AGENT: res.tag = hrhp_pkg::TAG_AGENT;
                  default:             res.tag = hrhp_pkg::TAG_CTYPE;
                endcase
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hrhp_queue.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser result queue
// Two-entry queue that parts the front end from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  hrhp_pkg::result_t       push_data,
  input  wire logic               pop,
  output hrhp_pkg::result_t       head,
  output hrhp_pkg::q_status_t     status
);

  hrhp_pkg::result_t mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

endmodule

`default_nettype wire

@@ rtl/core/http_request_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser unit
// Parses a request head word by word and delivers tagged field bytes,
// a completion record or a reject record.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_data_byte
//  out_    | output    | out_valid / out_ready | kind, tag, byte, length, seq, cause
//
//  One word per cycle; a word's result is pushed into the queue as it is accepted.
//  The front end updates all parse state in the cycle a word is accepted.
//  A two-entry result queue sets in_ready: input stalls only when it is full.
//  Reset (rst_n low, synchronous) clears parse state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_header_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_field_tag,
  output logic [7:0]       out_field_byte,
  output logic [30:0]      out_content_length,
  output logic [30:0]      out_sequence_number,
  output logic [2:0]       out_error_cause
);

  hrhp_pkg::result_t   fr_res;
  hrhp_pkg::result_t   q_head;
  hrhp_pkg::q_status_t q_stat;
  logic                fr_valid;
  logic                take;
  logic                push;

  // accept a word when the queue has room
  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;
  assign push     = take && fr_valid;

  hrhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .res       (fr_res),
    .res_valid (fr_valid)
  );

  hrhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (fr_res),
    .pop       (out_valid && out_ready),
    .head      (q_head),
    .status    (q_stat)
  );

  // drive result ports from the queue head
  assign out_valid           = !q_stat.empty;
  assign out_result_kind     = q_head.kind;
  assign out_field_tag       = q_head.tag;
  assign out_field_byte      = q_head.fbyte;
  assign out_content_length  = q_head.clen;
  assign out_sequence_number = q_head.seq;
  assign out_error_cause     = q_head.cause;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("pushed result not visible");

  a_reject_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (push && fr_res.kind == hrhp_pkg::KIND_REJECT) |-> (fr_res.cause != hrhp_pkg::ERR_NONE))
    else $error("reject without cause");
`endif

endmodule

`default_nettype wire

@@ tb/hrhp_checker.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser checker
// Watches both channels, runs a parse model on every accepted input word and
// compares each delivered result word, field by field, with the oldest
// predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_result_kind,
  input  wire logic [2:0]  out_field_tag,
  input  wire logic [7:0]  out_field_byte,
  input  wire logic [30:0] out_content_length,
  input  wire logic [30:0] out_sequence_number,
  input  wire logic [2:0]  out_error_cause,
  output int               fail_count,
  output int               pending_count
);

  hrhp_pkg::result_t pending_results[$];

  hrhp_pkg::phase_t phase;
  int           head_cnt;
  int           line_cnt;
  int           tok_cnt;
  logic [4:0]   name_mask;
  logic [2:0]   hdr_id;
  logic [30:0]  clen_acc;
  logic [30:0]  seq_acc;
  logic [1:0]   crlf_state;
  int           val_stage;
  bit           digits_stop;

  // lower-case header names and their lengths, in header id order
  string names[5] = '{"host", "user-agent", "content-length", "content-type",
                      "sequence-number"};

  assign pending_count = pending_results.size();

  function automatic void clear_line();
    line_cnt    = 0;
    tok_cnt     = 0;
    name_mask   = 5'h1F;
    hdr_id      = hrhp_pkg::HDR_NONE;
    val_stage   = 0;
    digits_stop = 0;
  endfunction

  function automatic void clear_parse();
    phase      = hrhp_pkg::PH_METHOD;
    head_cnt   = 0;
    clen_acc   = '0;
    seq_acc    = '0;
    crlf_state = 2'd0;
    clear_line();
  endfunction

  function automatic void push_result(hrhp_pkg::kind_t k, logic [2:0] tg, logic [7:0] b,
                                      logic [30:0] cl, logic [30:0] sq,
                                      logic [2:0] cs);
    hrhp_pkg::result_t r;
    r.kind  = k;
    r.tag   = tg;
    r.fbyte = b;
    r.clen  = cl;
    r.seq   = sq;
    r.cause = cs;
    pending_results.push_back(r);
  endfunction

  function automatic void reject_head(logic [2:0] cs);
    phase = hrhp_pkg::PH_SKIP;
    push_result(hrhp_pkg::KIND_REJECT, 3'd0, 8'd0, '0, '0, cs);
  endfunction

  function automatic logic [30:0] add_digit(logic [30:0] acc, logic [7:0] b);
    longint v;
    if (digits_stop) return acc;
    if (b < "0" || b > "9") begin
      digits_stop = 1;
      return acc;
    end
    v = longint'(acc) * 10 + (b - 8'h30);
    return (v > longint'(hrhp_pkg::SAT31)) ? hrhp_pkg::SAT31 : v[30:0];
  endfunction

  // advance the parse model by one word
  function automatic void parse_word(logic [7:0] b);
    logic [1:0]  prev;
    bit          eol;
    bit          fin;
    bit          blank;
    logic [7:0]  lc;
    logic [4:0]  alive;
    logic [30:0] cl;
    logic [30:0] sq;
    bit          was_skip;
    prev = crlf_state;
    eol  = 0;
    fin  = 0;
    if (b == hrhp_pkg::CH_CR) begin
      crlf_state = (prev == 2'd2) ? 2'd3 : 2'd1;
      eol = 1;
    end else if (b == hrhp_pkg::CH_LF) begin
      if (prev == 2'd3) fin = 1;
      else if (prev == 2'd1) crlf_state = 2'd2;
      else begin
        crlf_state = 2'd0;
        eol = 1;
      end
    end else begin
      crlf_state = 2'd0;
    end
    if (head_cnt < hrhp_pkg::HEAD_LIMIT) head_cnt++;

    if (fin) begin
      was_skip = (phase == hrhp_pkg::PH_SKIP);
      cl = clen_acc;
      sq = seq_acc;
      clear_parse();
      if (!was_skip)
        push_result(hrhp_pkg::KIND_DONE, 3'd0, 8'd0, cl, sq, hrhp_pkg::ERR_NONE);
      return;
    end
    if (phase == hrhp_pkg::PH_SKIP) return;
    if (head_cnt + 1 >= hrhp_pkg::HEAD_LIMIT) begin
      reject_head(hrhp_pkg::ERR_HEAD);
      return;
    end
    if (eol) begin
      if (phase inside {hrhp_pkg::PH_METHOD, hrhp_pkg::PH_GAP1, hrhp_pkg::PH_PATH,
                        hrhp_pkg::PH_GAP2}) begin
        reject_head(hrhp_pkg::ERR_RLINE);
        return;
      end
      if (phase == hrhp_pkg::PH_VALUE && val_stage == 0) begin
        reject_head(hrhp_pkg::ERR_VALUE);
        return;
      end
      phase = hrhp_pkg::PH_NAME;
      clear_line();
      return;
    end
    if (b == hrhp_pkg::CH_LF) return;

    line_cnt++;
    if (line_cnt >= hrhp_pkg::LINE_LIMIT) begin
      reject_head(hrhp_pkg::ERR_LINE);
      return;
    end
    blank = (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB);

    case (phase)
      hrhp_pkg::PH_METHOD: begin
        if (blank) begin
          if (tok_cnt == 0) reject_head(hrhp_pkg::ERR_RLINE);
          else phase = hrhp_pkg::PH_GAP1;
        end else if (tok_cnt + 1 >= hrhp_pkg::METHOD_LIMIT) begin
          reject_head(hrhp_pkg::ERR_RLINE);
        end else begin
          tok_cnt++;
          push_result(hrhp_pkg::KIND_FIELD, hrhp_pkg::TAG_METHOD, b, '0, '0,
                      hrhp_pkg::ERR_NONE);
        end
      end
      hrhp_pkg::PH_GAP1, hrhp_pkg::PH_GAP2, hrhp_pkg::PH_PATH, hrhp_pkg::PH_VERSION: begin
        if (phase == hrhp_pkg::PH_GAP1 || phase == hrhp_pkg::PH_GAP2) begin
          if (blank) return;
          tok_cnt = 0;
          phase = (phase == hrhp_pkg::PH_GAP1) ? hrhp_pkg::PH_PATH : hrhp_pkg::PH_VERSION;
        end
        if (phase == hrhp_pkg::PH_PATH) begin
          if (blank) phase = hrhp_pkg::PH_GAP2;
          else if (tok_cnt + 1 >= hrhp_pkg::PATH_LIMIT) reject_head(hrhp_pkg::ERR_RLINE);
          else begin
            tok_cnt++;
            push_result(hrhp_pkg::KIND_FIELD, hrhp_pkg::TAG_PATH, b, '0, '0,
                        hrhp_pkg::ERR_NONE);
          end
        end else begin
          if (tok_cnt + 1 >= hrhp_pkg::VERSION_LIMIT) reject_head(hrhp_pkg::ERR_RLINE);
          else begin
            tok_cnt++;
            push_result(hrhp_pkg::KIND_FIELD, hrhp_pkg::TAG_VERSION, b, '0, '0,
                        hrhp_pkg::ERR_NONE);
          end
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (name_mask == 0) return;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        alive = '0;
        for (int i = 0; i < hrhp_pkg::NUM_HDR; i++)
          if (name_mask[i] && tok_cnt < names[i].len() && names[i][tok_cnt] == lc)
            alive[i] = 1'b1;
        name_mask = alive;
        tok_cnt++;
        for (int i = 0; i < hrhp_pkg::NUM_HDR; i++)
          if (alive[i] && names[i].len() == tok_cnt) begin
            hdr_id    = 3'(i + 1);
            phase     = hrhp_pkg::PH_VALUE;
            val_stage = 0;
          end
      end
      hrhp_pkg::PH_VALUE: begin
        if (val_stage == 0) begin
          if (b == hrhp_pkg::CH_COLON) begin
            val_stage   = 1;
            tok_cnt     = 0;
            digits_stop = 0;
            if (hdr_id == hrhp_pkg::HDR_CLEN) clen_acc = '0;
            if (hdr_id == hrhp_pkg::HDR_SEQ) seq_acc = '0;
          end
          return;
        end
        if (val_stage == 1) begin
          if (blank) return;
          val_stage = 2;
        end
        if (tok_cnt < hrhp_pkg::LINE_LIMIT) tok_cnt++;
        case (hdr_id)
          hrhp_pkg::HDR_CLEN: clen_acc = add_digit(clen_acc, b);
          hrhp_pkg::HDR_SEQ: begin
            if (tok_cnt >= hrhp_pkg::SEQUENCE_DIGITS) reject_head(hrhp_pkg::ERR_VALUE);
            else seq_acc = add_digit(seq_acc, b);
          end
          hrhp_pkg::HDR_HOST:
            push_result(hrhp_pkg::KIND_FIELD, hrhp_pkg::TAG_HOST, b, '0, '0,
                        hrhp_pkg::ERR_NONE);
          hrhp_pkg::HDR_AGENT:
            push_result(hrhp_pkg::KIND_FIELD, hrhp_pkg::TAG_AGENT, b, '0, '0,
                        hrhp_pkg::ERR_NONE);
          hrhp_pkg::HDR_CTYPE:
            push_result(hrhp_pkg::KIND_FIELD, hrhp_pkg::TAG_CTYPE, b, '0, '0,
                        hrhp_pkg::ERR_NONE);
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // predict on accepted input words, compare on accepted result words
  always @(posedge clk) begin
    hrhp_pkg::result_t want;
    if (!rst_n) begin
      clear_parse();
      pending_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: kind %0d tag %0d byte %02h",
                     out_result_kind, out_field_tag, out_field_byte);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_result_kind !== want.kind || out_field_tag !== want.tag ||
              out_field_byte !== want.fbyte || out_content_length !== want.clen ||
              out_sequence_number !== want.seq || out_error_cause !== want.cause) begin
            if (fail_count < 10)
              $display({"mismatch: expected kind %0d tag %0d byte %02h len %0d ",
                        "seq %0d cause %0d, got %0d %0d %02h %0d %0d %0d"},
                       want.kind, want.tag, want.fbyte, want.clen, want.seq,
                       want.cause, out_result_kind, out_field_tag, out_field_byte,
                       out_content_length, out_sequence_number, out_error_cause);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) parse_word(in_data_byte);
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_http_request_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Feeds directed and random request heads through the parser under several
// idle and stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_http_request_header_parser_unit;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_field_tag;
  logic [7:0]  out_field_byte;
  logic [30:0] out_content_length;
  logic [30:0] out_sequence_number;
  logic [2:0]  out_error_cause;
  int          fail_count;
  int          pending_count;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  int  words_sent = 0;
  int  quiet_cycles = 0;
  byte stream[$];

  always #5 clk = ~clk;

  http_request_header_parser_unit dut (.*);

  hrhp_checker checker_i (.*);

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  function automatic string rand_token(int n);
    string s;
    byte   c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = 8'(8'h21 + $urandom_range(93));
      if (c == ":") c = "a";
      s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic string rand_case(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if ($urandom_range(1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
    return r;
  endfunction

  function automatic string blanks();
    string s;
    s = "";
    repeat ($urandom_range(1, 2)) s = {s, $urandom_range(1) ? " " : "\t"};
    return s;
  endfunction

  // queue one random, mostly well-formed request head
  task automatic add_random_head();
    int    n;
    int    sel;
    string nm;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 30);
      repeat (n) stream.push_back(8'($urandom_range(255)));
      add_text("\r\n\r\n");
      return;
    end
    add_text({rand_token($urandom_range(1, 5)), blanks(),
              rand_token($urandom_range(1, 6)), blanks(),
              rand_token($urandom_range(1, 8))});
    if ($urandom_range(9) == 0) add_text(rand_token($urandom_range(8, 14)));
    add_text($urandom_range(7) == 0 ? "\n" : "\r\n");
    n = $urandom_range(0, 4);
    repeat (n) begin
      sel = $urandom_range(6);
      case (sel)
        0: nm = "host";
        1: nm = "user-agent";
        2: nm = "content-length";
        3: nm = "content-type";
        4: nm = "sequence-number";
        5: nm = "hos";
        default: nm = "x-other";
      endcase
      add_text(rand_case(nm));
      if ($urandom_range(11) != 0) add_text(":");
      if ($urandom_range(1)) add_text(blanks());
      if (sel == 2 || sel == 4) begin
        case ($urandom_range(3))
          0: add_text($sformatf("%0d", $urandom_range(99999)));
          1: add_text($sformatf("%0d%0d", $urandom, $urandom));
          2: add_text({"-", $sformatf("%0d", $urandom_range(99))});
          default: add_text("");
        endcase
      end else begin
        add_text(rand_token($urandom_range(0, 6)));
      end
      add_text($urandom_range(7) == 0 ? "\n" : "\r\n");
    end
    add_text("\r\n");
  endtask

  // offer every queued word, idling at random between them
  task automatic send_stream();
    while (stream.size() > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= stream.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      words_sent++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, all headers, request-line and value faults
    add_text("GET /index.html HTTP/1.1\r\nHost: Ex.com\r\nUSER-AGENT:\tab\r\n");
    add_text("content-length: 2147483648999\r\ncontent-type:x/y\r\n");
    add_text("Sequence-Number: 42\r\nX-Other: zz\r\n\r\n");
    stream.push_back(8'hFF); stream.push_back(8'h00); add_text(" \x80 \x7F\r\n\r\n");
    add_text(" GET / V\r\n\r\n");
    add_text("GET /\r\n\r\n");
    add_text("ABCDEFGHIJKLMNOP / V\r\n\r\n");
    add_text("A / 0123456789ABCDEFG\r\n\r\n");
    add_text("A / V\r\nHost x\r\n\r\n");
    add_text("A / V\r\nsequence-number: 12345678901234567\r\n\r\n");
    add_text("A / V\nContent-Length: +5\n\r\n\r\n");
    send_stream();
    drain();

    // random phases with different idle and stall patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 47 : 20) : 0;
      recv_stall_pct = (ph == 2) ? 47 : ((ph == 3) ? 20 : 0);
      if (ph == 2) hold_off_cycles = 300;
      while (stream.size() < 40) add_random_head();
      send_stream();
      if (ph == 1) drain();
    end
    recv_stall_pct = 0;

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
